// ===== rtl/crlfll_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlfll_pkg
// Shared types and constants for the CR LF normalizer and line locator.
// ----------------------------------------------------------------------------
package crlfll_pkg;

	localparam int unsigned MAX_LINES = 4096;
	localparam int unsigned ADDR_W    = $clog2(MAX_LINES);
	localparam int unsigned LC_W      = ADDR_W + 1;
	localparam int unsigned POS_W     = 21;
	localparam int unsigned QPOS_W    = 20;
	localparam logic [POS_W-1:0] MAX_CHARS = POS_W'(1048576);
	localparam logic [LC_W-1:0]  LC_FULL   = LC_W'(MAX_LINES);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_LOC  = 1'b1;

	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_PTR_W = 2;
	localparam int unsigned OQ_CNT_W = 3;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data;
		logic [LC_W-1:0]  line;
		logic [POS_W-1:0] col;
		logic             ovf;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_COMPARE,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/crlfll_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlfll_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module crlfll_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crlfll_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlfll_outq
// Result queue; takes up to two results per cycle, releases one.
// ----------------------------------------------------------------------------
module crlfll_outq (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire crlfll_pkg::push_t                     push,
	input  wire logic                                  pop,
	output logic      [crlfll_pkg::OQ_CNT_W-1:0]       count,
	output crlfll_pkg::result_t                        head
);

	crlfll_pkg::result_t ent_q [crlfll_pkg::OQ_DEPTH];
	logic [crlfll_pkg::OQ_PTR_W-1:0] head_q;
	logic [crlfll_pkg::OQ_PTR_W-1:0] tail_q;
	logic [crlfll_pkg::OQ_CNT_W-1:0] count_q;
	logic [crlfll_pkg::OQ_PTR_W-1:0] tail_nx;

	assign tail_nx = tail_q + crlfll_pkg::OQ_PTR_W'(1);
	assign count   = count_q;
	assign head    = ent_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + crlfll_pkg::OQ_PTR_W'(1);
			end
			tail_q  <= tail_q + crlfll_pkg::OQ_PTR_W'(push.n);
			count_q <= count_q + crlfll_pkg::OQ_CNT_W'(push.n)
				- crlfll_pkg::OQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[tail_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			ent_q[tail_nx] <= push.r1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crlfll_ram_dummy_guard.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlfll_pos_step
// Saturating advance of the output position for one emitted byte.
// ----------------------------------------------------------------------------
module crlfll_pos_step (
	input  wire logic                            en,
	input  wire logic [crlfll_pkg::POS_W-1:0]    pos,
	output logic      [crlfll_pkg::POS_W-1:0]    pos_next,
	output logic                                 sat
);

	always_comb begin
		pos_next = pos;
		sat      = 1'b0;
		if (en) begin
			if (pos < crlfll_pkg::MAX_CHARS) begin
				pos_next = pos + crlfll_pkg::POS_W'(1);
			end else begin
				sat = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crlf_normalizer_line_locator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_normalizer_line_locator_core
// CR LF normalizer with a line start table and a binary search locator.
// ----------------------------------------------------------------------------
// A source byte item yields zero, one or two byte results; the block takes
// it whenever the four-entry result queue has room for two results, so a
// stream of bytes runs at one item per cycle while the consumer keeps up. A
// query item runs a binary search over the line start RAM with at most
// floor(log2(line count)) + 1 probes; each probe reads the RAM, then compares
// on the registered read data. No item is taken during a query.
// Line starts are 21-bit words in a 4096-entry RAM; entry zero is never
// written and is read as zero. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module crlf_normalizer_line_locator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [7:0]  in_byte,
	input  wire logic        final_byte,
	input  wire logic [19:0] query_position,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic      [7:0]  out_byte,
	output logic      [12:0] line_number,
	output logic      [20:0] column_number,
	output logic             overflow,
	output logic             last_of_run
);

	localparam int unsigned LC_W   = crlfll_pkg::LC_W;
	localparam int unsigned ADDR_W = crlfll_pkg::ADDR_W;
	localparam int unsigned POS_W  = crlfll_pkg::POS_W;
	localparam int unsigned QPOS_W = crlfll_pkg::QPOS_W;

	crlfll_pkg::state_t state_q, state_d;

	logic [LC_W-1:0]   line_count_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              cr_pending_q;
	logic              ovf_q;

	logic [QPOS_W-1:0] qpos_q;
	logic [LC_W-1:0]   lo_q, hi_q;
	logic [ADDR_W-1:0] mid_q, idx_q;
	logic              zero_rd_q;

	logic [crlfll_pkg::OQ_CNT_W-1:0] oq_count;
	crlfll_pkg::result_t oq_head;
	crlfll_pkg::push_t   push;

	logic in_acc, byte_acc, query_acc, out_acc;

	// byte path
	logic             a_v, b_v, consumed, pend_d;
	logic [7:0]       a_b;
	logic [POS_W-1:0] pos_a, pos_b, lf_pos;
	logic             sat_a, sat_b, lf_a, lf_b, lf_any, table_full, ovf_d;
	crlfll_pkg::result_t res_a, res_b;

	// search path
	logic [LC_W-1:0]   mid, lo_m1;
	logic [POS_W-1:0]  rd_data, start;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic              probe_go;
	logic              start_le;
	crlfll_pkg::result_t res_q;

	assign in_ready  = (state_q == crlfll_pkg::ST_IDLE)
		&& (oq_count <= crlfll_pkg::OQ_CNT_W'(crlfll_pkg::OQ_DEPTH - 2));
	assign in_acc    = in_valid && in_ready;
	assign byte_acc  = in_acc && (command == crlfll_pkg::CMD_BYTE);
	assign query_acc = in_acc && (command == crlfll_pkg::CMD_QUERY);
	assign out_valid = (oq_count != '0);
	assign out_acc   = out_valid && out_ready;

	always_comb begin
		consumed = cr_pending_q && (in_byte == crlfll_pkg::CH_LF);
		a_v      = cr_pending_q;
		a_b      = consumed ? crlfll_pkg::CH_LF : crlfll_pkg::CH_CR;
		b_v      = !consumed && ((in_byte != crlfll_pkg::CH_CR) || final_byte);
		pend_d   = !consumed && (in_byte == crlfll_pkg::CH_CR) && !final_byte;
	end

	crlfll_pos_step u_step_a (
		.en       (a_v),
		.pos      (out_pos_q),
		.pos_next (pos_a),
		.sat      (sat_a)
	);

	crlfll_pos_step u_step_b (
		.en       (b_v),
		.pos      (pos_a),
		.pos_next (pos_b),
		.sat      (sat_b)
	);

	always_comb begin
		lf_a       = a_v && (a_b == crlfll_pkg::CH_LF);
		lf_b       = b_v && (in_byte == crlfll_pkg::CH_LF);
		lf_any     = lf_a || lf_b;
		lf_pos     = lf_a ? pos_a : pos_b;
		table_full = (line_count_q == crlfll_pkg::LC_FULL);
		wr_en      = byte_acc && lf_any && !table_full;
		ovf_d      = ovf_q || sat_a || sat_b || (lf_any && table_full);

		res_a      = '0;
		res_a.kind = crlfll_pkg::KIND_BYTE;
		res_a.data = a_b;
		res_a.ovf  = ovf_d;
		res_a.last = !b_v;
		res_b      = '0;
		res_b.kind = crlfll_pkg::KIND_BYTE;
		res_b.data = in_byte;
		res_b.ovf  = ovf_d;
		res_b.last = 1'b1;
	end

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_m1    = (lo_q != '0) ? (lo_q - LC_W'(1)) : '0;
	assign probe_go = (lo_q < hi_q);
	assign start    = zero_rd_q ? '0 : rd_data;
	assign start_le = (start <= POS_W'(qpos_q));

	always_comb begin
		res_q      = '0;
		res_q.kind = crlfll_pkg::KIND_LOC;
		res_q.line = LC_W'(idx_q) + LC_W'(1);
		res_q.col  = POS_W'(qpos_q) - start + POS_W'(1);
		res_q.ovf  = ovf_q;
		res_q.last = 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crlfll_pkg::ST_IDLE: begin
				if (query_acc) begin
					state_d = crlfll_pkg::ST_PROBE;
				end
			end
			crlfll_pkg::ST_PROBE: begin
				state_d = probe_go ? crlfll_pkg::ST_COMPARE : crlfll_pkg::ST_FINISH;
			end
			crlfll_pkg::ST_COMPARE: begin
				state_d = crlfll_pkg::ST_PROBE;
			end
			crlfll_pkg::ST_FINISH: begin
				state_d = crlfll_pkg::ST_IDLE;
			end
			default: begin
				state_d = crlfll_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		push    = '0;
		unique case (state_q)
			crlfll_pkg::ST_IDLE: begin
				if (byte_acc) begin
					push.n  = 2'(a_v) + 2'(b_v);
					push.r0 = a_v ? res_a : res_b;
					push.r1 = res_b;
				end
			end
			crlfll_pkg::ST_PROBE: begin
				rd_en   = 1'b1;
				rd_addr = probe_go ? mid[ADDR_W-1:0] : lo_m1[ADDR_W-1:0];
			end
			crlfll_pkg::ST_COMPARE: begin
			end
			crlfll_pkg::ST_FINISH: begin
				push.n  = 2'd1;
				push.r0 = res_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= crlfll_pkg::ST_IDLE;
			line_count_q <= LC_W'(1);
			out_pos_q    <= '0;
			cr_pending_q <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (byte_acc) begin
				out_pos_q    <= pos_b;
				cr_pending_q <= pend_d;
				ovf_q        <= ovf_d;
				if (wr_en) begin
					line_count_q <= line_count_q + LC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			qpos_q <= query_position;
			lo_q   <= '0;
			hi_q   <= line_count_q;
		end
		if (state_q == crlfll_pkg::ST_PROBE) begin
			zero_rd_q <= (rd_addr == '0);
			mid_q     <= mid[ADDR_W-1:0];
			idx_q     <= lo_m1[ADDR_W-1:0];
		end
		if (state_q == crlfll_pkg::ST_COMPARE) begin
			if (start_le) begin
				lo_q <= LC_W'(mid_q) + LC_W'(1);
			end else begin
				hi_q <= LC_W'(mid_q);
			end
		end
	end

	crlfll_ram #(
		.WIDTH (POS_W),
		.DEPTH (crlfll_pkg::MAX_LINES)
	) u_line_starts (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (line_count_q[ADDR_W-1:0]),
		.wr_data (lf_pos),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	crlfll_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (out_acc),
		.count  (oq_count),
		.head   (oq_head)
	);

	assign kind          = oq_head.kind;
	assign out_byte      = oq_head.data;
	assign line_number   = oq_head.line;
	assign column_number = oq_head.col;
	assign overflow      = oq_head.ovf;
	assign last_of_run   = oq_head.last;

	a_lc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(line_count_q != '0) && (line_count_q <= crlfll_pkg::LC_FULL))
		else $error("line count out of range");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != crlfll_pkg::ST_IDLE) |-> !in_ready)
		else $error("item taken during a query");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crlfll_pkg::ST_FINISH) |=> (state_q == crlfll_pkg::ST_IDLE))
		else $error("query did not return to idle");

	a_q_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		oq_count <= crlfll_pkg::OQ_CNT_W'(crlfll_pkg::OQ_DEPTH))
		else $error("result queue overrun");

endmodule

`default_nettype wire
